@@ rtl/slle_pkg.sv @@
// Shared types, constants and the control-store program for the static linked list engine.
// Depends on nothing; imported by static_linked_list_engine.
package slle_pkg;

	// Field widths fixed by the stream words
	localparam int POS_W   = 10;
	localparam int VAL_W   = 32;
	localparam int LEN_W   = 10;
	localparam int DEF_NODES = 1024;

	// Operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	// Status codes
	localparam logic ST_OK  = 1'b0;
	localparam logic ST_ERR = 1'b1;

	// Microprogram steps
	typedef enum logic [4:0] {
		U_CLR     = 5'd0,
		U_IDLE    = 5'd1,
		U_DISP    = 5'd2,
		U_ICHK    = 5'd3,
		U_IFRESH  = 5'd4,
		U_IUNLINK = 5'd5,
		U_DCHK    = 5'd6,
		U_PRIME   = 5'd7,
		U_WALK    = 5'd8,
		U_SUCC    = 5'd9,
		U_ILINK1  = 5'd10,
		U_ILINK2  = 5'd11,
		U_DGONE   = 5'd12,
		U_DBYP    = 5'd13,
		U_DFREE   = 5'd14,
		U_DPUSH   = 5'd15,
		U_ERR     = 5'd16,
		U_OUT     = 5'd17
	} upc_t;

	// Jump conditions
	typedef enum logic [3:0] {
		C_ALWAYS, C_ACCEPT, C_CLR_LAST, C_BAD_INS, C_BAD_DEL,
		C_RD_ZERO, C_POS_ONE, C_K_EQ, C_OP_DEL, C_OUT_BUSY
	} cond_t;

	// Link store read address source
	typedef enum logic [1:0] {RA_ZERO, RA_HEAD, RA_RDATA, RA_AT} ra_t;

	// Link store write address source
	typedef enum logic [2:0] {WA_CLR, WA_ZERO, WA_FRESH, WA_AT, WA_GONE} wa_t;

	// Link store write data source
	typedef enum logic [1:0] {WD_INIT, WD_RDATA, WD_FRESH, WD_GONE} wd_t;

	// Result register update
	typedef enum logic [1:0] {RS_NONE, RS_ERR, RS_INS_OK, RS_DEL_OK} rs_t;

	// Element count update
	typedef enum logic [1:0] {CN_NONE, CN_INC, CN_DEC} cn_t;

	// One control word
	typedef struct packed {
		logic  in_rdy;
		ra_t   ra;
		logic  we;
		wa_t   wa;
		wd_t   wd;
		logic  val_we;
		logic  clr_inc;
		logic  at_head;
		logic  ld_at;
		logic  ld_fresh;
		logic  ld_gone;
		logic  ld_removed;
		logic  k_init;
		logic  k_inc;
		rs_t   rs;
		cn_t   cn;
		logic  out_load;
		cond_t cond;
		upc_t  jt;
		upc_t  jf;
	} ctl_t;

	// Control store: one word per step, jump to jt when cond holds, else jf
	function automatic ctl_t ucode(input upc_t pc);
		ctl_t c;
		c = '0;
		c.cond = C_ALWAYS;
		c.jt = U_IDLE;
		c.jf = U_IDLE;
		case (pc)
			U_CLR: begin
				c.we = 1'b1; c.wa = WA_CLR; c.wd = WD_INIT; c.clr_inc = 1'b1;
				c.cond = C_CLR_LAST; c.jt = U_IDLE; c.jf = U_CLR;
			end
			U_IDLE: begin
				c.in_rdy = 1'b1; c.at_head = 1'b1;
				c.cond = C_ACCEPT; c.jt = U_DISP; c.jf = U_IDLE;
			end
			U_DISP: begin
				c.cond = C_OP_DEL; c.jt = U_DCHK; c.jf = U_ICHK;
			end
			U_ICHK: begin
				c.ra = RA_ZERO;
				c.cond = C_BAD_INS; c.jt = U_ERR; c.jf = U_IFRESH;
			end
			U_IFRESH: begin
				c.ld_fresh = 1'b1; c.ra = RA_RDATA;
				c.cond = C_RD_ZERO; c.jt = U_ERR; c.jf = U_IUNLINK;
			end
			U_IUNLINK: begin
				c.we = 1'b1; c.wa = WA_ZERO; c.wd = WD_RDATA; c.val_we = 1'b1;
				c.jt = U_PRIME;
			end
			U_DCHK: begin
				c.cond = C_BAD_DEL; c.jt = U_ERR; c.jf = U_PRIME;
			end
			U_PRIME: begin
				c.ra = RA_HEAD; c.k_init = 1'b1;
				c.cond = C_POS_ONE; c.jt = U_SUCC; c.jf = U_WALK;
			end
			U_WALK: begin
				c.ld_at = 1'b1; c.ra = RA_RDATA; c.k_inc = 1'b1;
				c.cond = C_K_EQ; c.jt = U_SUCC; c.jf = U_WALK;
			end
			U_SUCC: begin
				c.ra = RA_AT;
				c.cond = C_OP_DEL; c.jt = U_DGONE; c.jf = U_ILINK1;
			end
			U_ILINK1: begin
				c.we = 1'b1; c.wa = WA_FRESH; c.wd = WD_RDATA;
				c.jt = U_ILINK2;
			end
			U_ILINK2: begin
				c.we = 1'b1; c.wa = WA_AT; c.wd = WD_FRESH;
				c.cn = CN_INC; c.rs = RS_INS_OK; c.jt = U_OUT;
			end
			U_DGONE: begin
				c.ld_gone = 1'b1; c.ra = RA_RDATA;
				c.cond = C_RD_ZERO; c.jt = U_ERR; c.jf = U_DBYP;
			end
			U_DBYP: begin
				c.we = 1'b1; c.wa = WA_AT; c.wd = WD_RDATA;
				c.ld_removed = 1'b1; c.ra = RA_ZERO; c.jt = U_DFREE;
			end
			U_DFREE: begin
				c.we = 1'b1; c.wa = WA_GONE; c.wd = WD_RDATA;
				c.jt = U_DPUSH;
			end
			U_DPUSH: begin
				c.we = 1'b1; c.wa = WA_ZERO; c.wd = WD_GONE;
				c.cn = CN_DEC; c.rs = RS_DEL_OK; c.jt = U_OUT;
			end
			U_ERR: begin
				c.rs = RS_ERR; c.jt = U_OUT;
			end
			U_OUT: begin
				c.out_load = 1'b1;
				c.cond = C_OUT_BUSY; c.jt = U_OUT; c.jf = U_IDLE;
			end
			default: begin
				c.jt = U_IDLE; c.jf = U_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

@@ rtl/slle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module slle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/static_linked_list_engine.sv @@
// A good insert or delete walks the list from the head to position p before its result is
// loaded; an error on a bad position or a full store skips the walk.
// Throughput: one word at a time, and the walk follows one link per cycle.
// A new word is taken while a result waits.
// Reset: asynchronous, active low; then a clearing pass over every node seeds the free list,
// during which no input word is taken.
module static_linked_list_engine #(
	parameter int NODES = slle_pkg::DEF_NODES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [47:0]                     s_tdata,  // position[9:0], value[41:10], zero pad
	input  logic                            s_tuser,  // op
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [47:0]                     m_tdata,  // removed_value[31:0], length[41:32], pad
	output logic                            m_tuser   // status
);
	import slle_pkg::*;

	localparam int IW = $clog2(NODES);
	localparam int CW = ((IW > POS_W) ? IW : POS_W) + 1;
	localparam logic [IW-1:0] HEAD = IW'(NODES - 1);
	localparam logic [IW:0]   SEED_LIM = (IW+1)'(NODES - 2);

	// sequencer
	upc_t upc_q, upc_d;
	ctl_t ctl;
	logic cond_true;

	// datapath registers
	logic                    op_q;
	logic [POS_W-1:0]        pos_q;
	logic [VAL_W-1:0]        val_q;
	logic [IW-1:0]           at_q, fresh_q, gone_q, clr_q, cnt_q;
	logic [POS_W-1:0]        k_q;
	logic                    status_q;
	logic [VAL_W-1:0]        removed_q;
	logic                    out_valid_q, out_status_q;
	logic [VAL_W-1:0]        out_removed_q;
	logic [LEN_W-1:0]        out_len_q;

	// memories
	logic                    nx_we;
	logic [IW-1:0]           nx_waddr, nx_wdata, nx_raddr, nx_rdata;
	logic [VAL_W-1:0]        vl_rdata;

	logic                    accept, out_busy, bad_ins, bad_del;
	logic [CW-1:0]           pos_x, cnt_x;

	// link store: next pointers
	slle_ram #(.WIDTH(IW), .DEPTH(NODES)) u_next (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (nx_raddr),
		.rdata (nx_rdata)
	);

	// element store: values, never read before written
	slle_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_value (
		.clk   (clk),
		.we    (ctl.val_we),
		.waddr (fresh_q),
		.wdata (val_q),
		.raddr (nx_rdata),
		.rdata (vl_rdata)
	);

	// handshakes and range checks
	assign s_tready = ctl.in_rdy;
	assign accept   = s_tvalid && s_tready;
	assign out_busy = out_valid_q && !m_tready;
	assign pos_x    = CW'(pos_q);
	assign cnt_x    = CW'(cnt_q);
	assign bad_ins  = (pos_x == '0) || (pos_x > cnt_x + CW'(1));
	assign bad_del  = (pos_x == '0) || (pos_x > cnt_x);

	// control word, condition and next step
	always_comb begin
		ctl = ucode(upc_q);
		case (ctl.cond)
			C_ALWAYS:   cond_true = 1'b1;
			C_ACCEPT:   cond_true = accept;
			C_CLR_LAST: cond_true = (clr_q == HEAD);
			C_BAD_INS:  cond_true = bad_ins;
			C_BAD_DEL:  cond_true = bad_del;
			C_RD_ZERO:  cond_true = (nx_rdata == '0);
			C_POS_ONE:  cond_true = (pos_q == POS_W'(1));
			C_K_EQ:     cond_true = (k_q == pos_q);
			C_OP_DEL:   cond_true = (op_q == OP_DELETE);
			C_OUT_BUSY: cond_true = out_busy;
			default:    cond_true = 1'b0;
		endcase
		upc_d = cond_true ? ctl.jt : ctl.jf;
	end

	// link store address and data selection
	always_comb begin
		nx_we = ctl.we;
		case (ctl.ra)
			RA_ZERO:  nx_raddr = '0;
			RA_HEAD:  nx_raddr = HEAD;
			RA_RDATA: nx_raddr = nx_rdata;
			RA_AT:    nx_raddr = at_q;
			default:  nx_raddr = '0;
		endcase
		case (ctl.wa)
			WA_CLR:   nx_waddr = clr_q;
			WA_ZERO:  nx_waddr = '0;
			WA_FRESH: nx_waddr = fresh_q;
			WA_AT:    nx_waddr = at_q;
			WA_GONE:  nx_waddr = gone_q;
			default:  nx_waddr = '0;
		endcase
		case (ctl.wd)
			WD_INIT:  nx_wdata = ({1'b0, clr_q} < SEED_LIM) ? clr_q + IW'(1) : '0;
			WD_RDATA: nx_wdata = nx_rdata;
			WD_FRESH: nx_wdata = fresh_q;
			WD_GONE:  nx_wdata = gone_q;
			default:  nx_wdata = '0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q       <= U_CLR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= upc_d;
			if (ctl.clr_inc) begin
				clr_q <= clr_q + IW'(1);
			end
			case (ctl.cn)
				CN_INC:  cnt_q <= cnt_q + IW'(1);
				CN_DEC:  cnt_q <= cnt_q - IW'(1);
				default: cnt_q <= cnt_q;
			endcase
			if (ctl.out_load && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= s_tuser;
			pos_q <= s_tdata[POS_W-1:0];
			val_q <= s_tdata[POS_W+VAL_W-1:POS_W];
		end
		if (ctl.at_head) begin
			at_q <= HEAD;
		end else if (ctl.ld_at) begin
			at_q <= nx_rdata;
		end
		if (ctl.ld_fresh) begin
			fresh_q <= nx_rdata;
		end
		if (ctl.ld_gone) begin
			gone_q <= nx_rdata;
		end
		if (ctl.k_init) begin
			k_q <= POS_W'(2);
		end else if (ctl.k_inc) begin
			k_q <= k_q + POS_W'(1);
		end
		if (ctl.ld_removed) begin
			removed_q <= vl_rdata;
		end
		case (ctl.rs)
			RS_ERR: begin
				status_q  <= ST_ERR;
				removed_q <= '0;
			end
			RS_INS_OK: begin
				status_q  <= ST_OK;
				removed_q <= '0;
			end
			RS_DEL_OK: status_q <= ST_OK;
			default:   status_q <= status_q;
		endcase
		if (ctl.out_load && !out_busy) begin
			out_status_q  <= status_q;
			out_removed_q <= removed_q;
			out_len_q     <= cnt_x[LEN_W-1:0];
		end
	end

	// result word
	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {6'b0, out_len_q, out_removed_q};

`ifndef SYNTH
	// the list never holds more than the store allows
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= CW'(NODES - 2))
		else $error("element count beyond store capacity");

	// the count moves only at the final step of a successful insert or delete
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(upc_q) == U_ILINK2 || $past(upc_q) == U_DPUSH))
		else $error("element count changed outside a commit step");

	// an error word never carries a removed element
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == ST_ERR)) |-> (m_tdata[VAL_W-1:0] == '0))
		else $error("error result with non-zero removed value");
`endif

endmodule
